[sv/sra_pkg.sv]
`timescale 1ns / 1ps

package sra_pkg;

    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int LANES        = 5;
    localparam int COEF_W       = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int ANG_FRAC     = 16;
    localparam int ANG_W        = 29;
    localparam int ANGLE_W      = 12;
    localparam int QUOT_W       = ANG_W - ANG_FRAC;

    // q1.14 weights for sensor pairs at k*36 degrees
    localparam logic signed [COEF_W-1:0] COS_Q14 [LANES] = '{
        16'sd16384, 16'sd13255, 16'sd5063, -16'sd5063, -16'sd13255
    };
    localparam logic signed [COEF_W-1:0] SIN_Q14 [LANES] = '{
        16'sd0, 16'sd9631, 16'sd15583, 16'sd15583, 16'sd9631
    };

    // atan(2^-i) in tenths of a degree, 16 fraction bits
    localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        29'sd29491200, 29'sd17409673, 29'sd9198793, 29'sd4669451,
        29'sd2343786,  29'sd1173036,  29'sd586661,  29'sd293348,
        29'sd146676,   29'sd73339,    29'sd36669,   29'sd18335,
        29'sd9167,     29'sd4584,     29'sd2292,    29'sd1146,
        29'sd573,      29'sd286,      29'sd143,     29'sd72,
        29'sd36,       29'sd18,       29'sd9,       29'sd4
    };

    localparam logic signed [ANG_W-1:0] Z_QUARTER = ANG_W'(900 * 65536);
    localparam logic signed [ANG_W-1:0] Z_HALF    = ANG_W'(1800 * 65536);

    localparam logic signed [QUOT_W-1:0] ANGLE_MAX = QUOT_W'(1800);
    localparam logic signed [QUOT_W-1:0] ANGLE_MIN = -QUOT_W'(1800);

endpackage

[sv/sra_lane.sv]
`timescale 1ns / 1ps

module sra_lane #(
    parameter int SAMPLE_BITS = sra_pkg::SAMPLE_BITS_DEF,
    parameter int LANE        = 0,
    parameter int PROD_W      = SAMPLE_BITS + 1 + sra_pkg::COEF_W
) (
    input  logic                     clk,
    input  logic                     load,
    input  logic [SAMPLE_BITS-1:0]   sample_near,
    input  logic [SAMPLE_BITS-1:0]   sample_far,
    output logic signed [PROD_W-1:0] prod_cos,
    output logic signed [PROD_W-1:0] prod_sin
);
    import sra_pkg::*;

    logic signed [SAMPLE_BITS:0]  diff;
    logic signed [PROD_W-1:0]     prod_cos_reg;
    logic signed [PROD_W-1:0]     prod_sin_reg;
    logic signed [PROD_W-1:0]     prod_cos_next;
    logic signed [PROD_W-1:0]     prod_sin_next;

    always_comb
    begin
        diff          = $signed({1'b0, sample_near}) - $signed({1'b0, sample_far});
        prod_cos_next = PROD_W'(diff) * PROD_W'(COS_Q14[LANE]);
        prod_sin_next = PROD_W'(diff) * PROD_W'(SIN_Q14[LANE]);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_cos_reg <= prod_cos_next;
            prod_sin_reg <= prod_sin_next;
        end
    end

    assign prod_cos = prod_cos_reg;
    assign prod_sin = prod_sin_reg;

endmodule

[sv/sra_merge.sv]
`timescale 1ns / 1ps

module sra_merge #(
    parameter int PROD_W = sra_pkg::SAMPLE_BITS_DEF + 1 + sra_pkg::COEF_W,
    parameter int SUM_W  = PROD_W + 1
) (
    input  logic                     clk,
    input  logic                     load,
    input  logic signed [PROD_W-1:0] prod_cos [sra_pkg::LANES],
    input  logic signed [PROD_W-1:0] prod_sin [sra_pkg::LANES],
    output logic signed [SUM_W-1:0]  sum_x,
    output logic signed [SUM_W-1:0]  sum_y
);
    import sra_pkg::*;

    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic signed [SUM_W-1:0] sum_x_next;
    logic signed [SUM_W-1:0] sum_y_next;

    always_comb
    begin
        sum_x_next = '0;
        sum_y_next = '0;
        for (int k = 0; k < LANES; k++)
        begin
            sum_x_next = sum_x_next + SUM_W'(prod_cos[k]);
            sum_y_next = sum_y_next + SUM_W'(prod_sin[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

    assign sum_x = sum_x_reg;
    assign sum_y = sum_y_reg;

endmodule

[sv/sra_prep.sv]
`timescale 1ns / 1ps

module sra_prep #(
    parameter int SUM_W = sra_pkg::SAMPLE_BITS_DEF + 18,
    parameter int CW    = SUM_W + 2
) (
    input  logic                            clk,
    input  logic                            load,
    input  logic signed [SUM_W-1:0]         sum_x,
    input  logic signed [SUM_W-1:0]         sum_y,
    output logic signed [CW-1:0]            vec_x,
    output logic signed [CW-1:0]            vec_y,
    output logic signed [sra_pkg::ANG_W-1:0] vec_z
);
    import sra_pkg::*;

    logic signed [CW-1:0]    xe;
    logic signed [CW-1:0]    ye;
    logic signed [CW-1:0]    vec_x_reg;
    logic signed [CW-1:0]    vec_y_reg;
    logic signed [ANG_W-1:0] vec_z_reg;
    logic signed [CW-1:0]    vec_x_next;
    logic signed [CW-1:0]    vec_y_next;
    logic signed [ANG_W-1:0] vec_z_next;

    // axis cases finish here with y forced to zero so later stages pass through
    always_comb
    begin
        xe = CW'(sum_x);
        ye = CW'(sum_y);
        vec_x_next = xe;
        vec_y_next = ye;
        vec_z_next = '0;
        priority if (sum_y == '0)
        begin
            vec_y_next = '0;
            vec_z_next = sum_x[SUM_W-1] ? Z_HALF : '0;
        end
        else if (sum_x == '0)
        begin
            vec_y_next = '0;
            vec_z_next = sum_y[SUM_W-1] ? -Z_QUARTER : Z_QUARTER;
        end
        else if (sum_x[SUM_W-1] && !sum_y[SUM_W-1])
        begin
            vec_x_next = ye;
            vec_y_next = -xe;
            vec_z_next = Z_QUARTER;
        end
        else if (sum_x[SUM_W-1])
        begin
            vec_x_next = -ye;
            vec_y_next = xe;
            vec_z_next = -Z_QUARTER;
        end
        else
        begin
            vec_z_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vec_x_reg <= vec_x_next;
            vec_y_reg <= vec_y_next;
            vec_z_reg <= vec_z_next;
        end
    end

    assign vec_x = vec_x_reg;
    assign vec_y = vec_y_reg;
    assign vec_z = vec_z_reg;

endmodule

[sv/sra_cordic_stage.sv]
`timescale 1ns / 1ps

module sra_cordic_stage #(
    parameter int CW    = sra_pkg::SAMPLE_BITS_DEF + 20,
    parameter int SHIFT = 0
) (
    input  logic                             clk,
    input  logic                             load,
    input  logic signed [CW-1:0]             x_in,
    input  logic signed [CW-1:0]             y_in,
    input  logic signed [sra_pkg::ANG_W-1:0] z_in,
    output logic signed [CW-1:0]             x_out,
    output logic signed [CW-1:0]             y_out,
    output logic signed [sra_pkg::ANG_W-1:0] z_out
);
    import sra_pkg::*;

    logic signed [CW-1:0]    x_sh;
    logic signed [CW-1:0]    y_sh;
    logic signed [CW-1:0]    x_reg;
    logic signed [CW-1:0]    y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic signed [CW-1:0]    x_next;
    logic signed [CW-1:0]    y_next;
    logic signed [ANG_W-1:0] z_next;

    always_comb
    begin
        x_sh = x_in >>> SHIFT;
        y_sh = y_in >>> SHIFT;
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
        priority if (y_in == '0)
        begin
            z_next = z_in;
        end
        else if (!y_in[CW-1])
        begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + ATAN_TAB[SHIFT];
        end
        else
        begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - ATAN_TAB[SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

[sv/sensor_ring_angle_resolver.sv]
`timescale 1ns / 1ps
// sensor ring angle resolver
// input channel: ring_sample_0..9 with sample_valid / sample_stall; one
//   transaction is one set of ten sensor readings, sensor k facing opposite
//   sensor k+5
// output channel: angle_tenths with angle_valid / angle_stall; one transaction
//   per input, the direction atan2(y, x) in tenths of a degree, -1800..1800
// stages: lane multiply, pair merge, quadrant setup, a register for each cordic
//   stage, truncate and clamp, with cordic stages capped at 24
// throughput: one transaction per cycle while angle_stall holds no waiting result; every
//   stage is a register with its own valid bit and the pipeline is fully pipelined
// stall: when angle_stall holds a waiting result, earlier stages keep filling
//   into empty slots; sample_stall rises only once every stage holds a
//   transaction; the waiting result stays stable
// reset: rst_n clears all valid bits, the pipeline comes up empty
module sensor_ring_angle_resolver #(
    parameter int SAMPLE_BITS   = sra_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = sra_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic [SAMPLE_BITS-1:0]              ring_sample_0,
    input  logic [SAMPLE_BITS-1:0]              ring_sample_1,
    input  logic [SAMPLE_BITS-1:0]              ring_sample_2,
    input  logic [SAMPLE_BITS-1:0]              ring_sample_3,
    input  logic [SAMPLE_BITS-1:0]              ring_sample_4,
    input  logic [SAMPLE_BITS-1:0]              ring_sample_5,
    input  logic [SAMPLE_BITS-1:0]              ring_sample_6,
    input  logic [SAMPLE_BITS-1:0]              ring_sample_7,
    input  logic [SAMPLE_BITS-1:0]              ring_sample_8,
    input  logic [SAMPLE_BITS-1:0]              ring_sample_9,
    output logic                                angle_valid,
    input  logic                                angle_stall,
    output logic signed [sra_pkg::ANGLE_W-1:0]  angle_tenths
);
    import sra_pkg::*;

    localparam int NST    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int PROD_W = SAMPLE_BITS + 1 + COEF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CW     = SUM_W + 2;
    localparam int NSLOT  = NST + 4;
    localparam int CSTART = 3;

    logic [SAMPLE_BITS-1:0]  samples [2*LANES];
    logic signed [PROD_W-1:0] prod_cos [LANES];
    logic signed [PROD_W-1:0] prod_sin [LANES];
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic signed [CW-1:0]     cx [NST+1];
    logic signed [CW-1:0]     cy [NST+1];
    logic signed [ANG_W-1:0]  cz [NST+1];

    logic [NSLOT-1:0] valid_reg;
    logic [NSLOT-1:0] valid_next;
    logic [NSLOT-1:0] ready;

    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [ANGLE_W-1:0] angle_next;
    logic signed [ANG_W-1:0]   z_neg;
    logic signed [QUOT_W-1:0]  quot;

    assign samples[0] = ring_sample_0;
    assign samples[1] = ring_sample_1;
    assign samples[2] = ring_sample_2;
    assign samples[3] = ring_sample_3;
    assign samples[4] = ring_sample_4;
    assign samples[5] = ring_sample_5;
    assign samples[6] = ring_sample_6;
    assign samples[7] = ring_sample_7;
    assign samples[8] = ring_sample_8;
    assign samples[9] = ring_sample_9;

    // a slot loads when it is empty or its content moves on
    assign ready[NSLOT-1] = !valid_reg[NSLOT-1] || !angle_stall;
    genvar g;
    generate
        for (g = 0; g < NSLOT - 1; g++)
        begin : g_ready
            assign ready[g] = !valid_reg[g] || ready[g+1];
        end
    endgenerate

    always_comb
    begin
        valid_next = valid_reg;
        if (ready[0])
        begin
            valid_next[0] = sample_valid;
        end
        for (int s = 1; s < NSLOT; s++)
        begin
            if (ready[s])
            begin
                valid_next[s] = valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            sra_lane #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .LANE        (g),
                .PROD_W      (PROD_W)
            ) u_lane (
                .clk         (clk),
                .load        (ready[0]),
                .sample_near (samples[g]),
                .sample_far  (samples[g+LANES]),
                .prod_cos    (prod_cos[g]),
                .prod_sin    (prod_sin[g])
            );
        end
    endgenerate

    sra_merge #(
        .PROD_W   (PROD_W),
        .SUM_W    (SUM_W)
    ) u_merge (
        .clk      (clk),
        .load     (ready[1]),
        .prod_cos (prod_cos),
        .prod_sin (prod_sin),
        .sum_x    (sum_x),
        .sum_y    (sum_y)
    );

    sra_prep #(
        .SUM_W (SUM_W),
        .CW    (CW)
    ) u_prep (
        .clk   (clk),
        .load  (ready[2]),
        .sum_x (sum_x),
        .sum_y (sum_y),
        .vec_x (cx[0]),
        .vec_y (cy[0]),
        .vec_z (cz[0])
    );

    generate
        for (g = 0; g < NST; g++)
        begin : g_cordic
            sra_cordic_stage #(
                .CW    (CW),
                .SHIFT (g)
            ) u_stage (
                .clk   (clk),
                .load  (ready[CSTART+g]),
                .x_in  (cx[g]),
                .y_in  (cy[g]),
                .z_in  (cz[g]),
                .x_out (cx[g+1]),
                .y_out (cy[g+1]),
                .z_out (cz[g+1])
            );
        end
    endgenerate

    // truncate toward zero to whole tenths, then clamp
    always_comb
    begin
        z_neg = -cz[NST];
        if (cz[NST][ANG_W-1])
        begin
            quot = -$signed(z_neg[ANG_W-1:ANG_FRAC]);
        end
        else
        begin
            quot = $signed(cz[NST][ANG_W-1:ANG_FRAC]);
        end
        priority if (quot > ANGLE_MAX)
        begin
            angle_next = ANGLE_W'(ANGLE_MAX);
        end
        else if (quot < ANGLE_MIN)
        begin
            angle_next = ANGLE_W'(ANGLE_MIN);
        end
        else
        begin
            angle_next = ANGLE_W'(quot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[NSLOT-1])
        begin
            angle_reg <= angle_next;
        end
    end

    assign sample_stall = !ready[0];
    assign angle_valid  = valid_reg[NSLOT-1];
    assign angle_tenths = angle_reg;

endmodule
